/* src/egs_pkg.sv */
// Shared constants, types and format helpers for the epsilon-greedy arm selector.
`default_nettype none

package egs_pkg;

    localparam int NUM_ARMS    = 16;
    localparam int MEAN_BITS   = 16;
    localparam int COUNT_BITS  = 32;

    // Fixed widths of the request, result and configuration fields.
    localparam int ARM_W       = 4;
    localparam int Q16_W       = 16;
    localparam int NUMARMS_W   = 5;
    localparam int EPS_W       = 17;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 17;

    localparam int IDX_W       = $clog2(NUM_ARMS);
    localparam int NA_W        = $clog2(NUM_ARMS + 1);
    localparam int DIV_W       = (MEAN_BITS > Q16_W) ? MEAN_BITS : Q16_W;
    localparam int CMP_W       = (DIV_W + 1 > COUNT_BITS) ? DIV_W + 1 : COUNT_BITS;
    localparam int DSTEP_W     = $clog2(DIV_W + 1);
    localparam int ALIGN_SH    = (MEAN_BITS >= Q16_W) ? MEAN_BITS - Q16_W
                                                      : Q16_W - MEAN_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ARMS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 1'b1;

    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Token that walks down the row of arm cells.
    typedef struct packed {
        logic                  found;
        logic [IDX_W-1:0]      idx;
        logic [MEAN_BITS-1:0]  mean;
        logic [COUNT_BITS-1:0] count;
    } egs_tok_t;

    // Scan mode held steady while a token is in flight.
    typedef struct packed {
        logic             argmax;
        logic [IDX_W-1:0] target;
        logic [NA_W-1:0]  n_act;
    } egs_ctl_t;

    // Broadcast writes into the cells.
    typedef struct packed {
        logic                 inc;
        logic                 mean_we;
        logic [IDX_W-1:0]     arm;
        logic [MEAN_BITS-1:0] mean;
    } egs_wr_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_W-1:0]      dividend;
        logic [COUNT_BITS-1:0] divisor;
    } egs_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } egs_div_rsp_t;

    function automatic logic [MEAN_BITS-1:0] q16_to_mean(input logic [Q16_W-1:0] r);
        logic [MEAN_BITS+Q16_W-1:0] w;
        w = (MEAN_BITS+Q16_W)'(r);
        if (MEAN_BITS >= Q16_W)
            w = w << ALIGN_SH;
        else
            w = w >> ALIGN_SH;
        return w[MEAN_BITS-1:0];
    endfunction

    function automatic logic [Q16_W-1:0] mean_to_q16(input logic [MEAN_BITS-1:0] m);
        logic [MEAN_BITS+Q16_W-1:0] w;
        w = (MEAN_BITS+Q16_W)'(m);
        if (MEAN_BITS >= Q16_W)
            w = w >> ALIGN_SH;
        else
            w = w << ALIGN_SH;
        return w[Q16_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/egs_if.sv */
// Request and result channel interfaces of the arm selector.
`default_nettype none

interface egs_in_if import egs_pkg::*;;
    logic             valid;
    logic             ready;
    logic             op;
    logic [ARM_W-1:0] arm;
    logic [Q16_W-1:0] reward;
    logic [Q16_W-1:0] explore_draw;
    logic [Q16_W-1:0] arm_draw;

    modport source (output valid, op, arm, reward, explore_draw, arm_draw, input ready);
    modport sink   (input valid, op, arm, reward, explore_draw, arm_draw, output ready);
endinterface

interface egs_out_if import egs_pkg::*;;
    logic             valid;
    logic             ready;
    logic [ARM_W-1:0] chosen_arm;
    logic [Q16_W-1:0] arm_mean;
    logic             explored;

    modport source (output valid, chosen_arm, arm_mean, explored, input ready);
    modport sink   (input valid, chosen_arm, arm_mean, explored, output ready);
endinterface

`default_nettype wire

/* src/egs_cell.sv */
// One arm cell: holds the arm's mean and pull count and forwards the scan token.
`default_nettype none

module egs_cell import egs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] cell_idx,
    input  wire egs_ctl_t         ctl,
    input  wire egs_wr_t          wr,
    input  wire egs_tok_t         tok_in,
    output egs_tok_t              tok_out
);

    logic [MEAN_BITS-1:0]  mean_reg;
    logic [MEAN_BITS-1:0]  mean_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    egs_tok_t              tok_reg;
    egs_tok_t              tok_next;
    logic                  active;
    logic                  take;

    assign active = 32'(cell_idx) < 32'(ctl.n_act);

    // Greedy scans keep the first strictly larger mean, so ties stay at the lowest index.
    always_comb
    begin
        if (ctl.argmax)
            take = active && (!tok_in.found || (mean_reg > tok_in.mean));
        else
            take = (cell_idx == ctl.target);

        tok_next = tok_in;
        if (take)
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = cell_idx;
            tok_next.mean  = mean_reg;
            tok_next.count = count_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        mean_next  = mean_reg;
        if (wr.inc && (wr.arm == cell_idx) && (count_reg != '1))
            count_next = count_reg + 1'b1;
        if (wr.mean_we && (wr.arm == cell_idx))
            mean_next = wr.mean;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            mean_reg  <= mean_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

/* src/egs_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by the modulo and the mean update.
`default_nettype none

module egs_divider import egs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire egs_div_req_t req,
    output egs_div_rsp_t      rsp
);

    logic                  busy_reg;
    logic                  busy_next;
    logic [DSTEP_W-1:0]    step_reg;
    logic [DSTEP_W-1:0]    step_next;
    logic [DIV_W-1:0]      rem_reg;
    logic [DIV_W-1:0]      rem_next;
    logic [DIV_W-1:0]      quo_reg;
    logic [DIV_W-1:0]      quo_next;
    logic [COUNT_BITS-1:0] dvs_reg;
    logic [COUNT_BITS-1:0] dvs_next;
    logic [DIV_W:0]        trial;
    logic [CMP_W-1:0]      trial_sub;
    logic                  ge;
    logic                  done;

    // The partial remainder never exceeds the dividend bits shifted in so far.
    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign ge        = CMP_W'(trial) >= CMP_W'(dvs_reg);
    assign trial_sub = CMP_W'(trial) - CMP_W'(dvs_reg);
    assign done      = busy_reg && (step_reg == '0);

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = DSTEP_W'(DIV_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg && (step_reg != '0))
        begin
            step_next = step_reg - 1'b1;
            rem_next  = ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], ge};
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

/* src/epsilon_greedy_arm_selector_core.sv */
// Top level of the epsilon-greedy arm selector: control, arm cell row and divider.
//
//   channel   dir   handshake      payload
//   item      in    valid/ready    op, arm, reward, explore_draw, arm_draw
//   result    out   valid/ready    chosen_arm, arm_mean, explored
//   cfg       in    cfg_we         cfg_index, cfg_data (num_arms, epsilon)
//
// One request is in work at a time. A greedy select is one walk of the token down the row
// of arm cells; a random select and an update each add one pass of the 16-step divider,
// and an update of an inactive arm goes straight to the result.
// All per-arm state is in flip-flops cleared by rst_n, so the block is ready right after reset.
// The next request is taken while a finished result waits on a stalled result channel.
`default_nettype none

module epsilon_greedy_arm_selector_core import egs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    egs_in_if.sink                     item,
    egs_out_if.source                  result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [NUMARMS_W-1:0] num_arms_reg;
    logic [EPS_W-1:0]     epsilon_reg;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [NA_W-1:0]      cnt_reg;
    logic [NA_W-1:0]      cnt_next;
    logic                 op_reg;
    logic                 op_next;
    logic [IDX_W-1:0]     arm_reg;
    logic [IDX_W-1:0]     arm_next;
    logic [MEAN_BITS-1:0] reward_reg;
    logic [MEAN_BITS-1:0] reward_next;
    logic                 rnd_reg;
    logic                 rnd_next;
    logic                 first_done_reg;
    logic                 first_done_next;
    egs_ctl_t             ctl_reg;
    egs_ctl_t             ctl_next;
    logic [MEAN_BITS-1:0] cur_mean_reg;
    logic [MEAN_BITS-1:0] cur_mean_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic [ARM_W-1:0]     res_arm_reg;
    logic [ARM_W-1:0]     res_arm_next;
    logic [Q16_W-1:0]     res_mean_reg;
    logic [Q16_W-1:0]     res_mean_next;
    logic                 res_expl_reg;
    logic                 res_expl_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [ARM_W-1:0]     out_arm_reg;
    logic [ARM_W-1:0]     out_arm_next;
    logic [Q16_W-1:0]     out_mean_reg;
    logic [Q16_W-1:0]     out_mean_next;
    logic                 out_expl_reg;
    logic                 out_expl_next;

    logic [NA_W-1:0]      n_act;
    logic                 item_acc;
    logic                 rnd_pick;
    logic [MEAN_BITS-1:0] mag;
    logic [MEAN_BITS-1:0] q;
    logic [MEAN_BITS-1:0] new_mean;
    egs_wr_t              wr;
    egs_div_req_t         div_req;
    egs_div_rsp_t         div_rsp;
    egs_tok_t             tok [NUM_ARMS+1];
    egs_tok_t             tail;

    // Out-of-range arm counts clamp: zero acts as one, more than the built row as the built row.
    always_comb
    begin
        if (num_arms_reg == '0)
            n_act = NA_W'(1);
        else if (32'(num_arms_reg) > NUM_ARMS)
            n_act = NA_W'(NUM_ARMS);
        else
            n_act = NA_W'(num_arms_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_arms_reg <= NUMARMS_W'(16);
            epsilon_reg  <= EPS_W'(6554);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_ARMS: num_arms_reg <= cfg_data[NUMARMS_W-1:0];
                CFG_EPSILON:  epsilon_reg  <= cfg_data[EPS_W-1:0];
                default:      ;
            endcase
        end
    end

    // Row of arm cells; the first cell sees an empty token.
    assign tok[0] = '0;

    for (genvar g = 0; g < NUM_ARMS; g++)
    begin : g_cell
        egs_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(g)),
            .ctl      (ctl_reg),
            .wr       (wr),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1])
        );
    end

    assign tail = tok[NUM_ARMS];

    egs_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign rnd_pick   = !first_done_reg || (epsilon_reg == '0)
                        || (EPS_W'(item.explore_draw) < epsilon_reg);

    always_comb
    begin
        mag      = (reward_reg < tail.mean) ? (tail.mean - reward_reg)
                                            : (reward_reg - tail.mean);
        q        = div_rsp.quot[MEAN_BITS-1:0];
        new_mean = neg_reg ? (cur_mean_reg - q) : (cur_mean_reg + q);
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        arm_next        = arm_reg;
        reward_next     = reward_reg;
        rnd_next        = rnd_reg;
        first_done_next = first_done_reg;
        ctl_next        = ctl_reg;
        cur_mean_next   = cur_mean_reg;
        neg_next        = neg_reg;
        res_arm_next    = res_arm_reg;
        res_mean_next   = res_mean_reg;
        res_expl_next   = res_expl_reg;
        wr              = '0;
        div_req         = '0;

        out_valid_next  = out_valid_reg && !result.ready;
        out_arm_next    = out_arm_reg;
        out_mean_next   = out_mean_reg;
        out_expl_next   = out_expl_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    op_next  = item.op;
                    arm_next = IDX_W'(item.arm);
                    cnt_next = '0;
                    if (item.op == OP_UPDATE)
                    begin
                        if (32'(item.arm) >= 32'(n_act))
                        begin
                            res_arm_next  = item.arm;
                            res_mean_next = '0;
                            res_expl_next = 1'b0;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            wr.inc          = 1'b1;
                            wr.arm          = IDX_W'(item.arm);
                            reward_next     = q16_to_mean(item.reward);
                            ctl_next.argmax = 1'b0;
                            ctl_next.target = IDX_W'(item.arm);
                            ctl_next.n_act  = n_act;
                            state_next      = S_SCAN;
                        end
                    end
                    else
                    begin
                        first_done_next = 1'b1;
                        rnd_next        = rnd_pick;
                        ctl_next.n_act  = n_act;
                        if (rnd_pick)
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = DIV_W'(item.arm_draw);
                            div_req.divisor  = COUNT_BITS'(n_act);
                            state_next       = S_MOD;
                        end
                        else
                        begin
                            ctl_next.argmax = 1'b1;
                            ctl_next.target = '0;
                            state_next      = S_SCAN;
                        end
                    end
                end
            end

            S_MOD:
            begin
                if (div_rsp.done)
                begin
                    ctl_next.argmax = 1'b0;
                    ctl_next.target = div_rsp.rem[IDX_W-1:0];
                    cnt_next        = '0;
                    state_next      = S_SCAN;
                end
            end

            // The scan waits until the token has left the last cell.
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == NA_W'(NUM_ARMS))
                begin
                    if (op_reg == OP_UPDATE)
                    begin
                        cur_mean_next    = tail.mean;
                        neg_next         = reward_reg < tail.mean;
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(mag);
                        div_req.divisor  = tail.count;
                        state_next       = S_UPD;
                    end
                    else
                    begin
                        res_arm_next  = ARM_W'(tail.idx);
                        res_mean_next = mean_to_q16(tail.mean);
                        res_expl_next = rnd_reg;
                        state_next    = S_DONE;
                    end
                end
            end

            // The quotient of magnitudes with the sign put back truncates toward zero.
            S_UPD:
            begin
                if (div_rsp.done)
                begin
                    wr.mean_we    = 1'b1;
                    wr.arm        = arm_reg;
                    wr.mean       = new_mean;
                    res_arm_next  = ARM_W'(arm_reg);
                    res_mean_next = mean_to_q16(new_mean);
                    res_expl_next = 1'b0;
                    state_next    = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_arm_next   = res_arm_reg;
                    out_mean_next  = res_mean_reg;
                    out_expl_next  = res_expl_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            first_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            ctl_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            first_done_reg <= first_done_next;
            out_valid_reg  <= out_valid_next;
            ctl_reg        <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        arm_reg      <= arm_next;
        reward_reg   <= reward_next;
        rnd_reg      <= rnd_next;
        cur_mean_reg <= cur_mean_next;
        neg_reg      <= neg_next;
        res_arm_reg  <= res_arm_next;
        res_mean_reg <= res_mean_next;
        res_expl_reg <= res_expl_next;
        out_arm_reg  <= out_arm_next;
        out_mean_reg <= out_mean_next;
        out_expl_reg <= out_expl_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.chosen_arm = out_arm_reg;
    assign result.arm_mean   = out_mean_reg;
    assign result.explored   = out_expl_reg;

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the epsilon-greedy arm selector core.
`default_nettype none

module tb;
    import egs_pkg::*;

    typedef struct packed {
        logic             op;
        logic [ARM_W-1:0] arm;
        logic [Q16_W-1:0] reward;
        logic [Q16_W-1:0] explore_draw;
        logic [Q16_W-1:0] arm_draw;
    } arm_req_t;

    typedef struct packed {
        logic [ARM_W-1:0] arm;
        logic [Q16_W-1:0] mean;
        logic             explored;
    } arm_pick_t;

    // Tracks the bandit state and the picks the block still owes.
    class bandit_board;
        logic [MEAN_BITS-1:0]  mean_v [NUM_ARMS];
        logic [COUNT_BITS-1:0] pulls [NUM_ARMS];
        bit                    picked_once;
        logic [NUMARMS_W-1:0]  arms_reg;
        logic [EPS_W-1:0]      eps_reg;
        arm_pick_t             owed_picks [$];
        int                    errors;
        int                    checked;
        int                    selects;
        int                    random_picks;
        int                    updates;
        int                    idle_updates;

        function new();
            for (int i = 0; i < NUM_ARMS; i++)
            begin
                mean_v[i] = '0;
                pulls[i]  = '0;
            end
            picked_once  = 1'b0;
            arms_reg     = NUMARMS_W'(16);
            eps_reg      = EPS_W'(6554);
            errors       = 0;
            checked      = 0;
            selects      = 0;
            random_picks = 0;
            updates      = 0;
            idle_updates = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_NUM_ARMS)
                arms_reg = data[NUMARMS_W-1:0];
            else if (idx == CFG_EPSILON)
                eps_reg = data[EPS_W-1:0];
        endfunction

        function int active_arms();
            if (arms_reg == 0)
                return 1;
            if (arms_reg > NUM_ARMS)
                return NUM_ARMS;
            return int'(arms_reg);
        endfunction

        function longint scaled_reward(input logic [Q16_W-1:0] r);
            longint unsigned w;
            w = longint'(r);
            if (MEAN_BITS >= Q16_W)
                w = w << ALIGN_SH;
            else
                w = w >> ALIGN_SH;
            return longint'(w);
        endfunction

        function logic [Q16_W-1:0] mean_as_q16(input logic [MEAN_BITS-1:0] m);
            longint unsigned w;
            w = longint'(m);
            if (MEAN_BITS >= Q16_W)
                w = w >> ALIGN_SH;
            else
                w = w << ALIGN_SH;
            return w[Q16_W-1:0];
        endfunction

        function int pending();
            return owed_picks.size();
        endfunction

        // Advances the bandit state for one accepted request and queues the pick it owes.
        function void note_request(input arm_req_t r);
            arm_pick_t p;
            int        n;
            int        best;
            longint    cur;
            longint    delta;
            bit        rnd;
            n = active_arms();
            p.explored = 1'b0;
            if (r.op == OP_UPDATE)
            begin
                updates++;
                p.arm = r.arm;
                if (int'(r.arm) >= n)
                begin
                    idle_updates++;
                    p.mean = '0;
                end
                else
                begin
                    if (pulls[r.arm] != '1)
                        pulls[r.arm] = pulls[r.arm] + 1'b1;
                    cur   = longint'(mean_v[r.arm]);
                    // Signed division truncates toward zero, as the block must.
                    delta = (scaled_reward(r.reward) - cur) / longint'(pulls[r.arm]);
                    mean_v[r.arm] = MEAN_BITS'(cur + delta);
                    p.mean = mean_as_q16(mean_v[r.arm]);
                end
            end
            else
            begin
                selects++;
                rnd = !picked_once || eps_reg == 0 || EPS_W'(r.explore_draw) < eps_reg;
                picked_once = 1'b1;
                best = 0;
                if (rnd)
                begin
                    random_picks++;
                    best = int'(r.arm_draw) % n;
                end
                else
                begin
                    for (int i = 1; i < n; i++)
                        if (mean_v[i] > mean_v[best])
                            best = i;
                end
                p.arm      = ARM_W'(best);
                p.mean     = mean_as_q16(mean_v[best]);
                p.explored = rnd;
            end
            owed_picks.push_back(p);
        endfunction

        task report(input string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_result(input logic [ARM_W-1:0] arm, input logic [Q16_W-1:0] mean,
                          input logic explored);
            arm_pick_t want;
            checked++;
            if (owed_picks.size() == 0)
            begin
                report($sformatf("result arm %0d mean %0d with no request outstanding",
                                 arm, mean));
            end
            else
            begin
                want = owed_picks.pop_front();
                if (arm !== want.arm)
                    report($sformatf("chosen_arm %0d, expected %0d", arm, want.arm));
                if (mean !== want.mean)
                    report($sformatf("arm_mean %0d for arm %0d, expected %0d",
                                     mean, want.arm, want.mean));
                if (explored !== want.explored)
                    report($sformatf("explored %0b for arm %0d, expected %0b",
                                     explored, want.arm, want.explored));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    calm;
    int                    settings;
    bandit_board           board;

    egs_in_if  item_if ();
    egs_out_if result_if ();

    epsilon_greedy_arm_selector_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_if),
        .result    (result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: timed out with %0d results outstanding", board.pending());
        $display("tb failed");
        $finish;
    end

    // Result side: stalls in random bursts until the final calm stretch.
    initial
    begin
        result_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            board.check_result(result_if.chosen_arm, result_if.arm_mean, result_if.explored);
    end

    task automatic send_request(input arm_req_t r);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        item_if.valid        <= 1'b1;
        item_if.op           <= r.op;
        item_if.arm          <= r.arm;
        item_if.reward       <= r.reward;
        item_if.explore_draw <= r.explore_draw;
        item_if.arm_draw     <= r.arm_draw;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        board.note_request(r);
    endtask

    task automatic send_fields(input logic op, input int arm, input int reward,
                               input int xdraw, input int adraw);
        arm_req_t r;
        r.op           = op;
        r.arm          = ARM_W'(arm);
        r.reward       = Q16_W'(reward);
        r.explore_draw = Q16_W'(xdraw);
        r.arm_draw     = Q16_W'(adraw);
        send_request(r);
    endtask

    task automatic random_request();
        arm_req_t r;
        int       n;
        n = board.active_arms();
        r.op = ($urandom_range(0, 1) == 1) ? OP_UPDATE : OP_SELECT;
        // Mostly arms in use, so the means actually move.
        if ($urandom_range(0, 3) != 0)
            r.arm = ARM_W'($urandom_range(0, n - 1));
        else
            r.arm = ARM_W'($urandom_range(0, NUM_ARMS - 1));
        case ($urandom_range(0, 7))
            0: r.reward = '0;
            1: r.reward = '1;
            default: r.reward = Q16_W'($urandom());
        endcase
        r.explore_draw = Q16_W'($urandom());
        r.arm_draw     = Q16_W'($urandom());
        send_request(r);
    endtask

    // Lets every owed result drain, then gives the block time to go fully idle.
    task automatic settle();
        item_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_setting(input int unsigned arms, input int unsigned eps);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NUM_ARMS;
        cfg_data  <= CFG_DATA_W'(arms);
        @(posedge clk);
        board.write_reg(CFG_NUM_ARMS, CFG_DATA_W'(arms));
        cfg_index <= CFG_EPSILON;
        cfg_data  <= CFG_DATA_W'(eps);
        @(posedge clk);
        board.write_reg(CFG_EPSILON, CFG_DATA_W'(eps));
        cfg_we    <= 1'b0;
        settings++;
    endtask

    task automatic directed_requests();
        // Reset settings: sixteen arms, epsilon near one tenth.
        send_fields(OP_SELECT, 0, 0, 16'hFFFF, 16'hFFFF);
        send_fields(OP_UPDATE, 0, 16'hFFFF, 0, 0);
        send_fields(OP_UPDATE, 15, 0, 16'hFFFF, 16'hFFFF);
        send_fields(OP_UPDATE, 7, 16'h8000, 0, 0);
        send_fields(OP_UPDATE, 7, 16'h0001, 0, 0);
        send_fields(OP_UPDATE, 0, 0, 0, 0);
        send_fields(OP_SELECT, 0, 0, 16'hFFFF, 0);
        send_fields(OP_SELECT, 0, 0, 6553, 16'h5A5A);
        send_fields(OP_SELECT, 0, 0, 6554, 16'h5A5A);
        // Arm nine ties arm zero, so the greedy pick must stay on the lower index.
        send_fields(OP_UPDATE, 9, 16'h8000, 0, 0);
        send_fields(OP_SELECT, 0, 0, 16'hFFFF, 0);
        settle();
        write_setting(3, 0);
        send_fields(OP_UPDATE, 3, 16'hFFFF, 0, 0);
        send_fields(OP_UPDATE, 15, 16'hFFFF, 0, 0);
        send_fields(OP_UPDATE, 2, 16'hFFFF, 0, 0);
        send_fields(OP_SELECT, 0, 0, 16'hFFFF, 16'hFFFF);
        settle();
        // A zero arm count acts as one, and epsilon of one means always explore.
        write_setting(0, 65536);
        send_fields(OP_SELECT, 0, 0, 16'hFFFF, 16'h1234);
        send_fields(OP_UPDATE, 1, 16'hFFFF, 0, 0);
        send_fields(OP_UPDATE, 0, 0, 0, 0);
        settle();
        write_setting(31, 131071);
        send_fields(OP_SELECT, 0, 0, 16'hFFFF, 16'hFFFF);
        send_fields(OP_UPDATE, 15, 16'hFFFF, 0, 0);
        settle();
        write_setting(16, 1);
        send_fields(OP_SELECT, 0, 0, 0, 16'h00FF);
        send_fields(OP_SELECT, 0, 0, 1, 16'h00FF);
        settle();
    endtask

    initial
    begin
        int unsigned arms_tab [8];
        int unsigned eps_tab [8];
        board    = new();
        calm     = 1'b0;
        settings = 1;
        arms_tab = '{16, 1, 2, 0, 31, 0, 16, 16};
        eps_tab  = '{3277, 0, 65536, 32768, 131071, 0, 1, 6554};
        // One phase takes a random setting with mostly greedy selects.
        arms_tab[5] = $urandom_range(1, 16);
        eps_tab[5]  = $urandom_range(0, 16384);

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_NUM_ARMS;
        cfg_data             <= '0;
        item_if.valid        <= 1'b0;
        item_if.op           <= OP_SELECT;
        item_if.arm          <= '0;
        item_if.reward       <= '0;
        item_if.explore_draw <= '0;
        item_if.arm_draw     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 7)
                calm = 1'b1;
            write_setting(arms_tab[phase], eps_tab[phase]);
            repeat (150) random_request();
            settle();
        end

        $display("tb: %0d requests: %0d selects (%0d random picks), %0d updates (%0d inactive)",
                 board.selects + board.updates, board.selects, board.random_picks,
                 board.updates, board.idle_updates);
        $display("tb: %0d results checked across %0d register settings, %0d mismatches",
                 board.checked, settings, board.errors);
        if (board.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/egs_pkg.sv
src/egs_if.sv
src/egs_cell.sv
src/egs_divider.sv
src/epsilon_greedy_arm_selector_core.sv
test/tb.sv
